// ----- hw/rtl/stls_pkg.sv -----
// Shared types, constants and label helpers of the spike train label scheduler.
`timescale 1ns / 1ps

package stls_pkg;

	// List geometry: one label list per hemisphere in a shared store.
	localparam int DRV_PER_HEMI = 128;
	localparam int IDX_W        = $clog2(DRV_PER_HEMI);
	localparam int CNT_W        = $clog2(DRV_PER_HEMI + 1);
	localparam int STORE_DEPTH  = 2 * DRV_PER_HEMI;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	// Field and register widths.
	localparam int DRV_W      = 7;
	localparam int VAL_W      = 5;
	localparam int LABEL_W    = 16;
	localparam int TIME_W     = 31;
	localparam int REPEAT_W   = 8;
	localparam int SPACING_W  = 16;
	localparam int TOTAL_W    = CNT_W + REPEAT_W;
	localparam int PROD_W     = TOTAL_W + SPACING_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Command queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b1;

	// Event size codes.
	localparam logic [1:0] PACK_NONE   = 2'd0;
	localparam logic [1:0] PACK_SINGLE = 2'd1;
	localparam logic [1:0] PACK_PAIR   = 2'd2;

	typedef struct packed {
		logic             cmd;
		logic             hemisphere;
		logic [DRV_W-1:0] driver_index;
		logic [VAL_W-1:0] drive_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         pack_size;
		logic [LABEL_W-1:0] label_first;
		logic [LABEL_W-1:0] label_second;
		logic [TIME_W-1:0]  event_time;
		logic               last;
	} result_t;

	typedef struct packed {
		logic               is_pull;
		logic               hemi;
		logic [LABEL_W-1:0] label;
	} q_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_ADDR,
		BK_DATA
	} bk_state_t;

	// Spike label of one driver activation.
	function automatic logic [LABEL_W-1:0] make_label(
		input logic             hemi,
		input logic [DRV_W-1:0] drv,
		input logic [VAL_W-1:0] val
	);
		logic [LABEL_W-1:0] lbl;
		lbl = (LABEL_W'(hemi) << 13) | (LABEL_W'(drv[1:0]) << 14)
			| (LABEL_W'(drv[DRV_W-1:2]) << 6)
			| (LABEL_W'(32) - LABEL_W'(val));
		return lbl;
	endfunction

	// Store address of entry idx in the list of hemisphere hemi.
	function automatic logic [ADDR_W-1:0] store_addr(
		input logic             hemi,
		input logic [IDX_W-1:0] idx
	);
		logic [ADDR_W-1:0] base;
		base = hemi ? ADDR_W'(DRV_PER_HEMI) : '0;
		return ADDR_W'(idx) + base;
	endfunction

	// Backward step with wrap to the end of a list of length len.
	function automatic logic [IDX_W-1:0] step_back(
		input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] len
	);
		logic [CNT_W-1:0] lm1;
		lm1 = len - CNT_W'(1);
		return (idx == '0) ? lm1[IDX_W-1:0] : idx - IDX_W'(1);
	endfunction

endpackage

// ----- hw/rtl/stls_front.sv -----
// Front end: takes command beats, drops no-op loads and forms spike labels.
`timescale 1ns / 1ps

module stls_front (
	input  logic              start,
	input  logic              q_full,
	input  stls_pkg::item_t   item,
	output logic              push,
	output stls_pkg::q_entry_t entry
);
	import stls_pkg::*;

	logic accept;
	logic useful;

	// A load with a zero value never changes state, so it is not queued.
	assign accept = start && !q_full;
	assign useful = (item.cmd == CMD_PULL) || (item.drive_value != '0);
	assign push   = accept && useful;

	// Queue entry carries the finished label so the back end only stores it.
	always_comb begin
		entry.is_pull = (item.cmd == CMD_PULL);
		entry.hemi    = item.hemisphere;
		entry.label   = make_label(item.hemisphere, item.driver_index, item.drive_value);
	end

endmodule

// ----- hw/rtl/stls_queue.sv -----
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module stls_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stls_pkg::q_entry_t push_data,
	input  logic               pop,
	output stls_pkg::q_entry_t pop_data,
	output logic               empty,
	output logic               full
);
	import stls_pkg::*;

	q_entry_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == Q_CNT_W'(Q_DEPTH));
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/stls_back.sv -----
// Back end: label store, list counters, configuration and event sequencer.
`timescale 1ns / 1ps

module stls_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  stls_pkg::q_entry_t                 q_data,
	output logic                               q_pop,
	input  logic                               cfg_we,
	input  logic [stls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stls_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               done,
	output stls_pkg::result_t                  result
);
	import stls_pkg::*;

	bk_state_t state_q, state_d;

	// Control state.
	logic [CNT_W-1:0]     cnt_lo_q, cnt_hi_q;
	logic                 emitting_q;
	logic [REPEAT_W-1:0]  repeat_q;
	logic [SPACING_W-1:0] spacing_q;
	logic [TOTAL_W-1:0]   emitted_q;
	logic [IDX_W-1:0]     short_idx_q, long_idx_q;
	logic                 done_q;

	// Schedule parameters captured per pull.
	logic                 long_hemi_q;
	logic [CNT_W-1:0]     max_q, min_q;
	logic [TOTAL_W-1:0]   total_q, singles_q;
	logic [1:0]           size_q;
	logic                 last_q;
	logic [TIME_W-1:0]    time_q;
	logic [LABEL_W-1:0]   rd_a_q, rd_b_q;
	result_t              result_q;

	logic [LABEL_W-1:0]   label_store [STORE_DEPTH];

	// Combinational helpers.
	logic                 is_load;
	logic [CNT_W-1:0]     load_cnt;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic                 calc_long_hemi;
	logic [CNT_W-1:0]     calc_max, calc_min;
	logic [TOTAL_W-1:0]   calc_total, calc_singles;
	logic                 sched_end;
	logic                 is_single;
	logic [IDX_W-1:0]     short_use;
	logic [ADDR_W-1:0]    addr_long, addr_short, addr_a;
	logic [TOTAL_W-1:0]   emit_next;
	logic [PROD_W-1:0]    time_full;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && q_data.is_pull) begin
					state_d = BK_CALC;
				end
			end
			BK_CALC: state_d = BK_ADDR;
			BK_ADDR: state_d = BK_DATA;
			BK_DATA: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop and label store write.
	always_comb begin
		q_pop     = (state_q == BK_IDLE) && !q_empty;
		is_load   = q_pop && !q_data.is_pull;
		load_cnt  = q_data.hemi ? cnt_hi_q : cnt_lo_q;
		mem_we    = is_load && !emitting_q && (load_cnt < CNT_W'(DRV_PER_HEMI));
		mem_waddr = store_addr(q_data.hemi, load_cnt[IDX_W-1:0]);
	end

	// Schedule size: the longer list (hemisphere 1 on a tie) sets the length.
	always_comb begin
		calc_long_hemi = !(cnt_lo_q > cnt_hi_q);
		calc_max       = calc_long_hemi ? cnt_hi_q : cnt_lo_q;
		calc_min       = calc_long_hemi ? cnt_lo_q : cnt_hi_q;
		calc_total     = TOTAL_W'(calc_max) * TOTAL_W'(repeat_q);
		calc_singles   = TOTAL_W'(calc_max - calc_min) * TOTAL_W'(repeat_q);
	end

	// Event selection: singles first, then pairs; short index reloads at the switch.
	always_comb begin
		sched_end  = (emitted_q >= total_q);
		is_single  = (emitted_q < singles_q);
		short_use  = (emitted_q == singles_q) ? IDX_W'(min_q - CNT_W'(1)) : short_idx_q;
		addr_long  = store_addr(long_hemi_q, long_idx_q);
		addr_short = store_addr(!long_hemi_q, short_use);
		addr_a     = is_single ? addr_long : addr_short;
		emit_next  = emitted_q + TOTAL_W'(1);
		time_full  = PROD_W'(emit_next) * PROD_W'(spacing_q);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_lo_q    <= '0;
			cnt_hi_q    <= '0;
			emitting_q  <= 1'b0;
			repeat_q    <= REPEAT_W'(1);
			spacing_q   <= SPACING_W'(1);
			emitted_q   <= '0;
			short_idx_q <= '0;
			long_idx_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == BK_DATA);

			// Register writes are locked out while a schedule is open.
			if (cfg_we && !emitting_q) begin
				case (cfg_index)
					CFG_REPEAT:  repeat_q  <= cfg_data[REPEAT_W-1:0];
					CFG_SPACING: spacing_q <= cfg_data[SPACING_W-1:0];
					default: ;
				endcase
			end

			// Append a label to its hemisphere's list.
			if (mem_we) begin
				if (q_data.hemi) begin
					cnt_hi_q <= cnt_hi_q + CNT_W'(1);
				end else begin
					cnt_lo_q <= cnt_lo_q + CNT_W'(1);
				end
			end

			case (state_q)
				BK_CALC: begin
					// First pull of a schedule opens it.
					if (!emitting_q) begin
						emitting_q  <= 1'b1;
						emitted_q   <= '0;
						short_idx_q <= '0;
						long_idx_q  <= (calc_max != '0) ?
							IDX_W'(calc_max - CNT_W'(1)) : '0;
					end
				end
				BK_ADDR: begin
					if (sched_end) begin
						cnt_lo_q    <= '0;
						cnt_hi_q    <= '0;
						emitting_q  <= 1'b0;
						emitted_q   <= '0;
						short_idx_q <= '0;
						long_idx_q  <= '0;
					end else begin
						if (!is_single) begin
							short_idx_q <= step_back(short_use, min_q);
						end
						long_idx_q <= step_back(long_idx_q, max_q);
						emitted_q  <= emit_next;
					end
				end
				default: ;
			endcase
		end
	end

	// Per-pull payload registers.
	always_ff @(posedge clk) begin
		if (state_q == BK_CALC) begin
			long_hemi_q <= calc_long_hemi;
			max_q       <= calc_max;
			min_q       <= calc_min;
			total_q     <= calc_total;
			singles_q   <= calc_singles;
		end
		if (state_q == BK_ADDR) begin
			size_q <= sched_end ? PACK_NONE : (is_single ? PACK_SINGLE : PACK_PAIR);
			last_q <= sched_end;
			time_q <= sched_end ? '0 : time_full[TIME_W-1:0];
		end
		if (state_q == BK_DATA) begin
			result_q.pack_size    <= size_q;
			result_q.label_first  <= (size_q == PACK_NONE) ? '0 : rd_a_q;
			result_q.label_second <= (size_q == PACK_PAIR) ? rd_b_q : '0;
			result_q.event_time   <= time_q;
			result_q.last         <= last_q;
		end
	end

	// Label store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			label_store[mem_waddr] <= q_data.label;
		end
		rd_a_q <= label_store[addr_a];
		rd_b_q <= label_store[addr_long];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hw/rtl/spike_train_label_scheduler.sv -----
// Top level of the spike train label scheduler: front end, command queue, back end.
// A pull accepted into an empty queue is popped, then holds the back end through CALC
// (schedule size), ADDR (store read) and DATA (result register) until its result shows.
// Loads go one per cycle while the back end is idle; a 4-entry queue absorbs bursts.
// Reset: arst_n clears lists, counters and queue at once; repeat_count and event_spacing
// return to 1; the label store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module spike_train_label_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  stls_pkg::item_t                 item,
	input  logic                            cfg_we,
	input  logic [stls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stls_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output stls_pkg::result_t               result
);
	import stls_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     pop;
	q_entry_t head_entry;
	logic     q_empty;
	logic     q_full;

	assign busy = q_full;

	// Command classification and label forming.
	stls_front u_front (
		.start  (start),
		.q_full (q_full),
		.item   (item),
		.push   (push),
		.entry  (push_entry)
	);

	// Decoupling queue.
	stls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.pop_data  (head_entry),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Store, configuration and event sequencing.
	stls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (head_entry),
		.q_pop     (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

// ----- hw/rtl/stls_checker.sv -----
// Port-level checks of the spike train label scheduler and their binding.
`timescale 1ns / 1ps

module stls_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            done,
	input stls_pkg::result_t               result
);
	import stls_pkg::*;

	// Results are spaced by the sequencer, never in adjacent cycles.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats in adjacent cycles");

	// The end marker carries no event.
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |-> result.pack_size == PACK_NONE
			&& result.event_time == '0 && result.label_first == '0
			&& result.label_second == '0)
		else $error("end marker carries event data");

	// Every other result is a real event.
	a_real_event: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> result.pack_size == PACK_SINGLE
			|| result.pack_size == PACK_PAIR)
		else $error("event without a valid size");

	// A single label leaves the second slot empty.
	a_single_second: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.pack_size == PACK_SINGLE |-> result.label_second == '0)
		else $error("single event with a second label");

	// No result appears as reset is released, before any pull can be taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result right after reset");

endmodule

bind spike_train_label_scheduler stls_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench of the spike train label scheduler: directed and random beats.
`timescale 1ns / 1ps

module tb_top;
	import stls_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_ITEMS   = 350;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	item_t                 item      = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  done;
	result_t               result;

	spike_train_label_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #1 clk = ~clk;

	// Shadow copy of the scheduler state, advanced once per accepted beat.
	logic [LABEL_W-1:0] lbl_mem [0:STORE_DEPTH-1];
	int                 len_lo, len_hi;
	int                 ev_count, short_pos, long_pos;
	bit                 in_schedule;
	int                 repeat_reg, spacing_reg;

	result_t expected_events[$];
	result_t head_event;
	int      fail_count  = 0;
	int      beats_sent  = 0;
	int      quiet_count = 0;
	bit      gaps_on     = 1'b0;

	// Label of one driver activation: lane, hemisphere, row and inverted value.
	function automatic logic [LABEL_W-1:0] spike_label(input logic hemi,
			input logic [DRV_W-1:0] drv, input logic [VAL_W-1:0] val);
		logic [VAL_W:0] inv;
		inv = 6'd32 - {1'b0, val};
		return {drv[1:0], hemi, 2'b00, drv[6:2], inv};
	endfunction

	function automatic int wrap_down(input int pos, input int len);
		return (pos == 0) ? len - 1 : pos - 1;
	endfunction

	function automatic void clear_schedule();
		len_lo      = 0;
		len_hi      = 0;
		ev_count    = 0;
		short_pos   = 0;
		long_pos    = 0;
		in_schedule = 1'b0;
	endfunction

	// Advance the shadow state by one beat and queue the event a pull produces.
	task automatic predict_beat(input item_t it);
		int      long_h, max_len, min_len, total, singles, k;
		result_t ev;
		if (it.cmd == CMD_LOAD) begin
			if (!in_schedule && it.drive_value != '0) begin
				if (it.hemisphere && len_hi < DRV_PER_HEMI) begin
					lbl_mem[DRV_PER_HEMI + len_hi] = spike_label(1'b1, it.driver_index,
						it.drive_value);
					len_hi++;
				end else if (!it.hemisphere && len_lo < DRV_PER_HEMI) begin
					lbl_mem[len_lo] = spike_label(1'b0, it.driver_index, it.drive_value);
					len_lo++;
				end
			end
		end else begin
			// The longer list leads; hemisphere 1 wins a tie.
			long_h  = (len_lo > len_hi) ? 0 : 1;
			max_len = long_h ? len_hi : len_lo;
			min_len = long_h ? len_lo : len_hi;
			total   = max_len * repeat_reg;
			singles = (max_len - min_len) * repeat_reg;
			if (!in_schedule) begin
				in_schedule = 1'b1;
				ev_count    = 0;
				short_pos   = 0;
				long_pos    = (max_len > 0) ? max_len - 1 : 0;
			end
			ev = '0;
			if (ev_count >= total) begin
				ev.pack_size = PACK_NONE;
				ev.last      = 1'b1;
				clear_schedule();
			end else begin
				k = ev_count;
				if (k < singles) begin
					ev.pack_size   = PACK_SINGLE;
					ev.label_first = lbl_mem[long_h * DRV_PER_HEMI + long_pos];
				end else begin
					if (k == singles)
						short_pos = min_len - 1;
					ev.pack_size    = PACK_PAIR;
					ev.label_first  = lbl_mem[(1 - long_h) * DRV_PER_HEMI + short_pos];
					ev.label_second = lbl_mem[long_h * DRV_PER_HEMI + long_pos];
					short_pos       = wrap_down(short_pos, min_len);
				end
				long_pos      = wrap_down(long_pos, max_len);
				ev.event_time = TIME_W'(longint'(k + 1) * longint'(spacing_reg));
				ev_count      = (k + 1) & 32'h7FFF;
			end
			expected_events = {expected_events, ev};
		end
	endtask

	task automatic note_failure(input string what, input result_t want, input result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s: expected size %0d first %h second %h time %0d last %0b",
				$time, what, want.pack_size, want.label_first, want.label_second,
				want.event_time, want.last);
			$display("%0t: %s: got size %0d first %h second %h time %0d last %0b",
				$time, what, got.pack_size, got.label_first, got.label_second,
				got.event_time, got.last);
		end
	endtask

	// Compare every result beat with the oldest outstanding event.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_events.size() == 0) begin
				note_failure("result with no pull outstanding", '0, result);
			end else begin
				head_event = expected_events.pop_front();
				if (result.pack_size !== head_event.pack_size
						|| result.label_first !== head_event.label_first
						|| result.label_second !== head_event.label_second
						|| result.event_time !== head_event.event_time
						|| result.last !== head_event.last)
					note_failure("event mismatch", head_event, result);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic pause(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Present one beat and hold it until the block takes it.
	task automatic send_beat(input item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 18));
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_beat(it);
		beats_sent++;
	endtask

	task automatic load_beat(input logic hemi, input logic [DRV_W-1:0] drv,
			input logic [VAL_W-1:0] val);
		item_t it;
		it.cmd          = CMD_LOAD;
		it.hemisphere   = hemi;
		it.driver_index = drv;
		it.drive_value  = val;
		send_beat(it);
	endtask

	// Pull beats carry random content in the unused fields.
	task automatic pull_beat();
		item_t it;
		it.cmd          = CMD_PULL;
		it.hemisphere   = 1'($urandom_range(0, 1));
		it.driver_index = DRV_W'($urandom_range(0, 127));
		it.drive_value  = VAL_W'($urandom_range(0, 31));
		send_beat(it);
	endtask

	task automatic random_load();
		load_beat(1'($urandom_range(0, 1)), DRV_W'($urandom_range(0, 127)),
			VAL_W'($urandom_range(0, 31)));
	endtask

	// Pull until the end marker; optionally mix in loads that must be ignored.
	task automatic pull_to_end(input bit noisy);
		do begin
			if (noisy && in_schedule && $urandom_range(0, 11) == 0)
				random_load();
			pull_beat();
		end while (in_schedule);
	endtask

	// Stop sending and wait until every event has come and the queue has settled.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (!in_schedule) begin
			case (idx)
				CFG_REPEAT:  repeat_reg = data[REPEAT_W-1:0];
				CFG_SPACING: spacing_reg = data;
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// An empty schedule returns the end marker, also after a zero-value load.
	task automatic test_empty_pull();
		pull_beat();
		load_beat(1'b0, 7'd5, 5'd0);
		pull_beat();
	endtask

	// Field extremes with equal list lengths, so hemisphere 1 leads and all are pairs.
	task automatic test_field_extremes();
		load_beat(1'b0, 7'd0, 5'd31);
		load_beat(1'b0, 7'd127, 5'd1);
		load_beat(1'b0, 7'd42, 5'd10);
		load_beat(1'b1, 7'd0, 5'd0);
		load_beat(1'b1, 7'd85, 5'd21);
		load_beat(1'b1, 7'd127, 5'd31);
		load_beat(1'b1, 7'd0, 5'd1);
		pull_beat();
		load_beat(1'b0, 7'd99, 5'd7);
		pull_to_end(1'b0);
	endtask

	// Overfill hemisphere 0; the surplus loads are dropped.
	task automatic test_full_list();
		int n;
		for (n = 0; n < DRV_PER_HEMI + 2; n++)
			load_beat(1'b0, DRV_W'($urandom_range(0, 127)), VAL_W'($urandom_range(1, 31)));
		load_beat(1'b1, 7'd64, 5'd16);
		load_beat(1'b1, 7'd3, 5'd2);
		pull_to_end(1'b0);
	endtask

	// Register extremes, and writes during a schedule that must not take effect.
	task automatic test_config_extremes();
		int n;
		write_reg(CFG_REPEAT, 16'h0000);
		load_beat(1'b1, 7'd5, 5'd3);
		pull_beat();
		write_reg(CFG_REPEAT, 16'hFFFF);
		write_reg(CFG_SPACING, 16'hFFFF);
		load_beat(1'b0, 7'd64, 5'd2);
		load_beat(1'b1, 7'd1, 5'd30);
		for (n = 0; n < 3; n++)
			pull_beat();
		write_reg(CFG_REPEAT, 16'h0002);
		write_reg(CFG_SPACING, 16'h0000);
		pull_to_end(1'b0);
		write_reg(CFG_SPACING, 16'h0000);
		write_reg(CFG_REPEAT, 16'h0003);
		load_beat(1'b0, 7'd10, 5'd4);
		load_beat(1'b0, 7'd20, 5'd8);
		load_beat(1'b1, 7'd30, 5'd12);
		pull_to_end(1'b0);
	endtask

	// Random schedules: mostly well-formed load phases followed by full pull runs.
	task automatic test_random_schedules();
		int first, cap, n_lo, n_hi, left_lo, left_hi, cut, n, sel;
		logic h;
		logic [CFG_DATA_W-1:0] data;
		first = beats_sent;
		while (beats_sent - first < RANDOM_ITEMS) begin
			gaps_on = (beats_sent - first < RANDOM_ITEMS * 4 / 5)
				&& $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 2) == 0) begin
				sel  = $urandom_range(0, 11);
				data = CFG_DATA_W'($urandom_range(0, 65535));
				data[7:0] = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255
					: 8'($urandom_range(1, 4));
				write_reg(CFG_REPEAT, data);
			end
			if ($urandom_range(0, 2) == 0) begin
				sel  = $urandom_range(0, 5);
				data = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF
					: CFG_DATA_W'($urandom_range(0, 65535));
				write_reg(CFG_SPACING, data);
			end
			// Keep schedules short; a long repeat gets tiny lists.
			cap = (repeat_reg == 0) ? 10 : 64 / repeat_reg;
			if (cap < 1)
				cap = 1;
			if (cap > 12)
				cap = 12;
			n_lo = $urandom_range(0, cap);
			n_hi = $urandom_range(0, cap);
			if ((repeat_reg == 1 || repeat_reg == 2) && $urandom_range(0, 24) == 0) begin
				if ($urandom_range(0, 1))
					n_lo = $urandom_range(120, 135);
				else
					n_hi = $urandom_range(120, 135);
			end
			// Now and then a pull cuts into the load phase.
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_lo + n_hi) : -1;
			left_lo = n_lo;
			left_hi = n_hi;
			for (n = 0; n < n_lo + n_hi; n++) begin
				if (n == cut)
					pull_beat();
				h = (left_hi == 0) ? 1'b0 : (left_lo == 0) ? 1'b1
					: 1'($urandom_range(0, 1));
				if (h)
					left_hi--;
				else
					left_lo--;
				load_beat(h, DRV_W'($urandom_range(0, 127)),
					($urandom_range(0, 7) == 0) ? 5'd0 : VAL_W'($urandom_range(1, 31)));
			end
			// Pause mid-schedule until all events are in, then try a register write.
			if ($urandom_range(0, 7) == 0) begin
				for (n = $urandom_range(1, 3); n > 0; n--)
					pull_beat();
				drain();
				if ($urandom_range(0, 1))
					write_reg(CFG_SPACING, CFG_DATA_W'($urandom_range(0, 65535)));
				else
					write_reg(CFG_REPEAT, CFG_DATA_W'($urandom_range(0, 8)));
			end
			pull_to_end(1'b1);
		end
	endtask

	initial begin
		repeat_reg  = 1;
		spacing_reg = 1;
		clear_schedule();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_pull();
		test_field_extremes();
		test_full_list();
		test_config_extremes();
		test_random_schedules();

		// Wait for the last events, then let the block settle.
		@(negedge clk);
		start <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
